/* design/qsp_pkg.sv */
// Shared types and constants for the quoted string parser.
// Used by qsp_step, qsp_out_buf and quoted_string_parser_core; no dependencies.
package qsp_pkg;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_R    = 8'h72;
    localparam logic [7:0] CHAR_N    = 8'h6E;
    localparam logic [7:0] CHAR_T    = 8'h74;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_TAB  = 8'h09;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_NO_CLOSE    = 2'd1,
        ERR_END_ESCAPE  = 2'd2,
        ERR_UNUSED      = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        CFG_ESCAPES = 2'd0,
        CFG_TWIN    = 2'd1,
        CFG_EMIT    = 2'd2,
        CFG_NONE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'b0001,
        PH_BODY       = 4'b0010,
        PH_ESCAPE     = 4'b0100,
        PH_QUOTE_SEEN = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_ended;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_byte_valid;
        logic       string_done;
        logic       byte_not_consumed;
        logic [1:0] error_code;
    } t_out_item;

    typedef struct packed {
        logic escapes_enabled;
        logic twin_quotes_enabled;
        logic emit_quote_marks;
    } t_cfg;

    typedef struct packed {
        logic      has_result;
        logic      latch_quote;
        t_phase    next_phase;
        t_out_item item;
    } t_step_res;

endpackage

/* design/quoted_string_parser_core.sv */
// Top level of the quoted string parser: config registers, phase state, result buffer.
// Depends on qsp_pkg, qsp_step and qsp_out_buf.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One input beat per cycle while o_in_ready is high; its result beat, if any, is
//  registered into the buffer. The phase and quote byte updates are the only loops
//  from byte to byte. A two-beat head/skid buffer takes results, so input keeps
//  flowing while one result waits; input ready drops only when both slots are full.
//  Reset (synchronous, active low) returns the phase to idle, clears the quote
//  byte and loads escapes on, twin quotes off, quote marks off. cfg is always ready.
module quoted_string_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  qsp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output qsp_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic               i_cfg_data
);
    import qsp_pkg::*;

    t_cfg       r_cfg;
    t_phase     r_phase;
    logic [7:0] r_quote;
    t_step_res  step;
    logic       in_accept;
    logic       push;
    logic       push_ready;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = push_ready;
    assign in_accept   = i_in_valid && push_ready;
    assign push        = in_accept && step.has_result;

    qsp_step u_step (
        .i_phase      (r_phase),
        .i_quote_char (r_quote),
        .i_cfg        (r_cfg),
        .i_item       (i_in_data),
        .o_res        (step)
    );

    qsp_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (step.item),
        .o_push_ready (push_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (o_out_data)
    );

    // Config writes: index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escapes_enabled     <= 1'b1;
            r_cfg.twin_quotes_enabled <= 1'b0;
            r_cfg.emit_quote_marks    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ESCAPES: r_cfg.escapes_enabled     <= i_cfg_data;
                CFG_TWIN:    r_cfg.twin_quotes_enabled <= i_cfg_data;
                CFG_EMIT:    r_cfg.emit_quote_marks    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Advance phase on each accepted beat; latch the quote byte on an opening quote.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_quote <= 8'h00;
        end else if (in_accept) begin
            r_phase <= step.next_phase;
            if (step.latch_quote) begin
                r_quote <= i_in_data.in_byte;
            end
        end
    end

    a_err_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error_code != ERR_NONE) |->
            (o_out_data.string_done && !o_out_data.out_byte_valid))
        else $error("error beat without string end");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && step.item.string_done) |=> (r_phase == PH_IDLE))
        else $error("phase not idle after string end");

    a_quote_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_IDLE && !i_in_data.stream_ended) |=>
            (r_quote == $past(i_in_data.in_byte) && r_phase == PH_BODY))
        else $error("opening quote not latched");

endmodule

/* design/qsp_step.sv */
// Per-byte phase logic of the quoted string parser: next phase and result.
// Depends on qsp_pkg.
module qsp_step (
    input  qsp_pkg::t_phase    i_phase,
    input  logic [7:0]         i_quote_char,
    input  qsp_pkg::t_cfg      i_cfg,
    input  qsp_pkg::t_in_item  i_item,
    output qsp_pkg::t_step_res o_res
);
    import qsp_pkg::*;

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CHAR_R:  r = CHAR_CR;
            CHAR_N:  r = CHAR_LF;
            CHAR_T:  r = CHAR_TAB;
            default: r = c;
        endcase
        return r;
    endfunction

    logic       is_quote;
    logic       ended;
    logic [7:0] b;

    assign b        = i_item.in_byte;
    assign ended    = i_item.stream_ended;
    assign is_quote = (b == i_quote_char);

    always_comb begin
        o_res = '0;
        o_res.next_phase = i_phase;
        o_res.item.error_code = ERR_NONE;
        case (i_phase)
            PH_IDLE: begin
                if (!ended) begin
                    o_res.latch_quote = 1'b1;
                    o_res.next_phase  = PH_BODY;
                    if (i_cfg.emit_quote_marks) begin
                        o_res.has_result          = 1'b1;
                        o_res.item.out_byte       = b;
                        o_res.item.out_byte_valid = 1'b1;
                    end
                end
            end
            PH_BODY: begin
                if (ended) begin
                    o_res.next_phase       = PH_IDLE;
                    o_res.has_result       = 1'b1;
                    o_res.item.string_done = 1'b1;
                    o_res.item.error_code  = ERR_NO_CLOSE;
                end else if (is_quote) begin
                    if (i_cfg.twin_quotes_enabled) begin
                        o_res.next_phase = PH_QUOTE_SEEN;
                    end else begin
                        o_res.next_phase          = PH_IDLE;
                        o_res.has_result          = 1'b1;
                        o_res.item.string_done    = 1'b1;
                        o_res.item.out_byte_valid = i_cfg.emit_quote_marks;
                        o_res.item.out_byte       = i_cfg.emit_quote_marks ? i_quote_char : 8'h00;
                    end
                end else if (b == BACKSLASH && i_cfg.escapes_enabled) begin
                    o_res.next_phase = PH_ESCAPE;
                end else begin
                    o_res.has_result          = 1'b1;
                    o_res.item.out_byte       = b;
                    o_res.item.out_byte_valid = 1'b1;
                end
            end
            PH_ESCAPE: begin
                if (ended) begin
                    o_res.next_phase       = PH_IDLE;
                    o_res.has_result       = 1'b1;
                    o_res.item.string_done = 1'b1;
                    o_res.item.error_code  = ERR_END_ESCAPE;
                end else begin
                    o_res.next_phase          = PH_BODY;
                    o_res.has_result          = 1'b1;
                    o_res.item.out_byte       = unescape(b);
                    o_res.item.out_byte_valid = 1'b1;
                end
            end
            PH_QUOTE_SEEN: begin
                o_res.has_result = 1'b1;
                if (!ended && is_quote) begin
                    o_res.next_phase          = PH_BODY;
                    o_res.item.out_byte       = i_quote_char;
                    o_res.item.out_byte_valid = 1'b1;
                end else begin
                    // close; a real byte here belongs to whatever follows the string
                    o_res.next_phase             = PH_IDLE;
                    o_res.item.string_done       = 1'b1;
                    o_res.item.byte_not_consumed = !ended;
                    o_res.item.out_byte_valid    = i_cfg.emit_quote_marks;
                    o_res.item.out_byte = i_cfg.emit_quote_marks ? i_quote_char : 8'h00;
                end
            end
            default: begin
                o_res.next_phase = PH_IDLE;
            end
        endcase
    end

endmodule

/* design/qsp_out_buf.sv */
// Two-beat result buffer: head register plus skid register.
// Depends on qsp_pkg.
module qsp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  qsp_pkg::t_out_item i_push_data,
    output logic               o_push_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output qsp_pkg::t_out_item o_data
);
    import qsp_pkg::*;

    logic      r_head_valid, n_head_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_head, n_head;
    t_out_item r_skid, n_skid;
    logic      pop;

    assign pop          = r_head_valid && i_ready;
    assign o_valid      = r_head_valid;
    assign o_data       = r_head;
    assign o_push_ready = !r_skid_valid;

    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_skid_valid = i_push;
                n_skid       = i_push_data;
            end else begin
                n_head_valid = i_push;
                n_head       = i_push_data;
            end
        end else if (i_push) begin
            if (!r_head_valid) begin
                n_head_valid = 1'b1;
                n_head       = i_push_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_push_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_head <= n_head;
        r_skid <= n_skid;
    end

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid holds a beat while head is empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !pop) |-> !i_push)
        else $error("push into a full buffer");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_skid_valid) |=> (r_head_valid && r_head == $past(r_skid)))
        else $error("skid beat lost on pop");

endmodule
